FILE: rtl/core/nscp_pkg.sv
// Shared types, codes and defaults for the nested scope cycle profiler.
package nscp_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_STACK_DEPTH = 1024;
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_ID_BITS     = 8;

    // Fixed field widths
    localparam int TS_W        = 64;
    localparam int CALLS_W     = 32;
    localparam int SCOPE_W     = 8;
    localparam int SLOT_IN_W   = 6;
    localparam int DEPTH_OUT_W = 11;
    localparam int CMP_W       = 10;

    localparam logic [CALLS_W-1:0] CALLS_MAX = '1;

    typedef enum logic [1:0] {
        FUNC_OPEN  = 2'd0,
        FUNC_CLOSE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_STACK_FULL  = 3'd1,
        STAT_STACK_EMPTY = 3'd2,
        STAT_ID_MISMATCH = 3'd3,
        STAT_TABLE_FULL  = 3'd4,
        STAT_SLOT_EMPTY  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RD1,
        S_CL1,
        S_CL2,
        S_CL3,
        S_OUT
    } state_t;

    // Table port controls
    typedef struct packed {
        logic map_rd;   // look up id -> slot
        logic ent_rd;   // read entry
        logic ent_wr;   // write entry
        logic alloc;    // bind id to next free slot
    } tbl_ctrl_t;

endpackage

FILE: rtl/core/nested_scope_cycle_profiler_core.sv
// Nested scope cycle profiler: an item opens or closes a scope, or reads one
// table slot, and gives exactly one result item. After reset the block first
// clears its id map, one entry per cycle, and takes no item until then. Items
// are worked one at a time through the frame memory and table memory, each
// with a registered read: a close goes through the read of the top frame, the
// read and update of the parent frame and the table read-modify-write. A
// finished result waits in the output register while the next item is
// accepted.
module nested_scope_cycle_profiler_core #(
    parameter int STACK_DEPTH = nscp_pkg::DEF_STACK_DEPTH,
    parameter int TABLE_DEPTH = nscp_pkg::DEF_TABLE_DEPTH,
    parameter int ID_BITS     = nscp_pkg::DEF_ID_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // scope_id[7:0], timestamp[71:8], slot[77:72]
    input  logic [1:0]   s_tuser,   // func[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [183:0] m_tdata,   // exclusive_cycles[63:0], entry_id[71:64],
                                    // entry_calls[103:72], entry_cycles[167:104],
                                    // stack_depth[178:168]
    output logic [2:0]   m_tuser    // status[2:0]
);
    import nscp_pkg::*;

    localparam int SA_W    = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int SLOT_W  = $clog2(TABLE_DEPTH);
    localparam int USED_W  = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               m_tvalid_reg;

    // Item and work registers
    func_t              func_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [63:0]        now_reg;
    logic [5:0]         slot_reg;
    logic [63:0]        elapsed_reg, child_reg, excl_reg;
    logic               hit_reg;
    logic [SLOT_W-1:0]  hslot_reg;

    // Result registers
    status_t            res_status_reg;
    logic [63:0]        res_excl_reg, res_cycles_reg;
    logic [ID_BITS-1:0] res_id_reg;
    logic [31:0]        res_calls_reg;
    logic [183:0]       m_tdata_reg;
    logic [2:0]         m_tuser_reg;

    // Memory ports
    logic               stk_rd_en, stk_wr_en;
    logic [SA_W-1:0]    stk_rd_addr, stk_wr_addr;
    logic [ID_BITS-1:0] fr_id, stk_wr_id;
    logic [63:0]        fr_start, fr_child, stk_wr_start, stk_wr_child;
    tbl_ctrl_t          tctl;
    logic [SLOT_W-1:0]  t_rd_slot, t_wr_slot;
    logic [31:0]        t_wr_calls, t_rd_calls;
    logic [63:0]        t_wr_cycles, t_rd_cycles;
    logic               clearing, map_hit;
    logic [SLOT_W-1:0]  map_slot;
    logic [ID_BITS-1:0] t_rd_id;
    logic [USED_W-1:0]  used;

    // Decisions
    logic               accept, out_free;
    logic               stack_full, open_ok, close_ok, read_ok, id_match, tbl_full;
    logic [DEPTH_W-1:0] depth_m1, depth_m2;
    logic [31:0]        calls_inc;

    nscp_stack #(.STACK_DEPTH(STACK_DEPTH), .ID_BITS(ID_BITS)) u_stack (
        .aclk     (aclk),
        .rd_en    (stk_rd_en),
        .rd_addr  (stk_rd_addr),
        .rd_id    (fr_id),
        .rd_start (fr_start),
        .rd_child (fr_child),
        .wr_en    (stk_wr_en),
        .wr_addr  (stk_wr_addr),
        .wr_id    (stk_wr_id),
        .wr_start (stk_wr_start),
        .wr_child (stk_wr_child)
    );

    nscp_table #(.TABLE_DEPTH(TABLE_DEPTH), .ID_BITS(ID_BITS)) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (tctl),
        .id        (id_reg),
        .rd_slot   (t_rd_slot),
        .wr_slot   (t_wr_slot),
        .wr_calls  (t_wr_calls),
        .wr_cycles (t_wr_cycles),
        .clearing  (clearing),
        .map_hit   (map_hit),
        .map_slot  (map_slot),
        .rd_id     (t_rd_id),
        .rd_calls  (t_rd_calls),
        .rd_cycles (t_rd_cycles),
        .used      (used)
    );

    // Shared decode terms
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign depth_m1   = depth_reg - DEPTH_W'(1);
    assign depth_m2   = depth_reg - DEPTH_W'(2);
    assign stack_full = (depth_reg == DEPTH_W'(STACK_DEPTH));
    assign open_ok    = (func_reg == FUNC_OPEN) && !stack_full;
    assign close_ok   = (func_reg == FUNC_CLOSE) && (depth_reg != '0);
    assign read_ok    = (func_reg == FUNC_READ) && (CMP_W'(slot_reg) < CMP_W'(used));
    assign id_match   = (fr_id == id_reg);
    assign tbl_full   = (used == USED_W'(TABLE_DEPTH));
    assign calls_inc  = (t_rd_calls == CALLS_MAX) ? t_rd_calls : t_rd_calls + 32'd1;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (!clearing) state_next = S_IDLE;
            S_IDLE:   if (accept) state_next = S_DECODE;
            S_DECODE: begin
                if (close_ok) state_next = S_CL1;
                else if (read_ok) state_next = S_RD1;
                else state_next = S_OUT;
            end
            S_RD1:    state_next = S_OUT;
            S_CL1:    state_next = id_match ? S_CL2 : S_OUT;
            S_CL2:    state_next = S_CL3;
            S_CL3:    state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
    end

    // Memory controls and depth update
    always_comb begin
        s_tready     = (state_reg == S_IDLE);
        depth_next   = depth_reg;
        stk_rd_en    = 1'b0;
        stk_rd_addr  = depth_m1[SA_W-1:0];
        stk_wr_en    = 1'b0;
        stk_wr_addr  = depth_reg[SA_W-1:0];
        stk_wr_id    = id_reg;
        stk_wr_start = now_reg;
        stk_wr_child = '0;
        tctl         = '0;
        t_rd_slot    = SLOT_W'(slot_reg);
        t_wr_slot    = used[SLOT_W-1:0];
        t_wr_calls   = 32'd1;
        t_wr_cycles  = excl_reg;
        case (state_reg)
            S_DECODE: begin
                if (open_ok) begin
                    stk_wr_en  = 1'b1;
                    depth_next = depth_reg + DEPTH_W'(1);
                end
                if (close_ok) begin
                    stk_rd_en   = 1'b1;
                    tctl.map_rd = 1'b1;
                end
                if (read_ok) begin
                    tctl.ent_rd = 1'b1;
                end
            end
            S_CL1: begin
                if (id_match) begin
                    depth_next  = depth_m1;
                    stk_rd_en   = (depth_reg > DEPTH_W'(1));
                    stk_rd_addr = depth_m2[SA_W-1:0];
                    tctl.ent_rd = map_hit;
                    t_rd_slot   = map_slot;
                end
            end
            S_CL2: begin
                // charge elapsed time to the parent frame
                stk_wr_en    = (depth_reg != '0);
                stk_wr_addr  = depth_m1[SA_W-1:0];
                stk_wr_id    = fr_id;
                stk_wr_start = fr_start;
                stk_wr_child = fr_child + elapsed_reg;
            end
            S_CL3: begin
                if (hit_reg) begin
                    tctl.ent_wr = 1'b1;
                    t_wr_slot   = hslot_reg;
                    t_wr_calls  = calls_inc;
                    t_wr_cycles = t_rd_cycles + excl_reg;
                end else if (!tbl_full) begin
                    tctl.ent_wr = 1'b1;
                    tctl.alloc  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            depth_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item, work and result registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    func_reg <= func_t'(s_tuser);
                    id_reg   <= ID_BITS'(s_tdata[7:0]);
                    now_reg  <= s_tdata[71:8];
                    slot_reg <= s_tdata[77:72];
                end
            end
            S_DECODE: begin
                res_excl_reg   <= '0;
                res_id_reg     <= '0;
                res_calls_reg  <= '0;
                res_cycles_reg <= '0;
                if (func_reg == FUNC_OPEN && stack_full) begin
                    res_status_reg <= STAT_STACK_FULL;
                end else if (func_reg == FUNC_CLOSE && !close_ok) begin
                    res_status_reg <= STAT_STACK_EMPTY;
                end else if (func_reg == FUNC_READ && !read_ok) begin
                    res_status_reg <= STAT_SLOT_EMPTY;
                end else begin
                    res_status_reg <= STAT_OK;
                end
            end
            S_RD1: begin
                res_id_reg     <= t_rd_id;
                res_calls_reg  <= t_rd_calls;
                res_cycles_reg <= t_rd_cycles;
            end
            S_CL1: begin
                if (!id_match) begin
                    res_status_reg <= STAT_ID_MISMATCH;
                end
                elapsed_reg <= now_reg - fr_start;
                child_reg   <= fr_child;
                hit_reg     <= map_hit;
                hslot_reg   <= map_slot;
            end
            S_CL2: begin
                excl_reg <= elapsed_reg - child_reg;
            end
            S_CL3: begin
                res_excl_reg <= excl_reg;
                if (hit_reg) begin
                    res_id_reg     <= id_reg;
                    res_calls_reg  <= calls_inc;
                    res_cycles_reg <= t_rd_cycles + excl_reg;
                end else if (!tbl_full) begin
                    res_id_reg     <= id_reg;
                    res_calls_reg  <= 32'd1;
                    res_cycles_reg <= excl_reg;
                end else begin
                    res_status_reg <= STAT_TABLE_FULL;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_tuser_reg <= res_status_reg;
                    m_tdata_reg <= {5'd0, DEPTH_OUT_W'(depth_reg), res_cycles_reg,
                                    res_calls_reg, SCOPE_W'(res_id_reg), res_excl_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready) else $error("item taken during map clear");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(STACK_DEPTH)) else $error("stack depth overflow");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("item taken while busy");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free) |=> m_tvalid) else $error("result lost");

endmodule

FILE: rtl/core/nscp_stack.sv
// Frame stack memory: id, start timestamp and child time per open scope.
module nscp_stack #(
    parameter int STACK_DEPTH = 1024,
    parameter int ID_BITS     = 8,
    localparam int SA_W       = $clog2(STACK_DEPTH)
) (
    input  logic               aclk,
    input  logic               rd_en,
    input  logic [SA_W-1:0]    rd_addr,
    output logic [ID_BITS-1:0] rd_id,
    output logic [63:0]        rd_start,
    output logic [63:0]        rd_child,
    input  logic               wr_en,
    input  logic [SA_W-1:0]    wr_addr,
    input  logic [ID_BITS-1:0] wr_id,
    input  logic [63:0]        wr_start,
    input  logic [63:0]        wr_child
);
    import nscp_pkg::*;

    localparam int FW = ID_BITS + 2 * TS_W;

    logic [FW-1:0] mem [STACK_DEPTH];
    logic [FW-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_id, wr_start, wr_child};
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rd_id    = rdata_reg[FW-1 -: ID_BITS];
    assign rd_start = rdata_reg[2*TS_W-1 -: TS_W];
    assign rd_child = rdata_reg[TS_W-1:0];

endmodule

FILE: rtl/core/nscp_table.sv
// Per-id statistics table: id->slot map, entry memory and fill count.
module nscp_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int ID_BITS     = 8,
    localparam int SLOT_W     = $clog2(TABLE_DEPTH),
    localparam int USED_W     = $clog2(TABLE_DEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  nscp_pkg::tbl_ctrl_t ctrl,
    input  logic [ID_BITS-1:0] id,
    input  logic [SLOT_W-1:0]  rd_slot,
    input  logic [SLOT_W-1:0]  wr_slot,
    input  logic [31:0]        wr_calls,
    input  logic [63:0]        wr_cycles,
    output logic               clearing,
    output logic               map_hit,
    output logic [SLOT_W-1:0]  map_slot,
    output logic [ID_BITS-1:0] rd_id,
    output logic [31:0]        rd_calls,
    output logic [63:0]        rd_cycles,
    output logic [USED_W-1:0]  used
);
    import nscp_pkg::*;

    localparam int MAP_DEPTH = 1 << ID_BITS;
    localparam int MW        = SLOT_W + 1;
    localparam int EW        = ID_BITS + CALLS_W + TS_W;

    logic [MW-1:0]     map_mem [MAP_DEPTH];
    logic [MW-1:0]     map_rdata_reg;
    logic [EW-1:0]     ent_mem [TABLE_DEPTH];
    logic [EW-1:0]     ent_rdata_reg;
    logic [ID_BITS:0]  clr_cnt_reg;
    logic [USED_W-1:0] used_reg;
    logic              map_we;
    logic [ID_BITS-1:0] map_waddr;
    logic [MW-1:0]     map_wdata;

    assign clearing = !clr_cnt_reg[ID_BITS];

    // Map write: clearing sweep first, then allocations
    always_comb begin
        map_we    = clearing || ctrl.alloc;
        map_waddr = clearing ? clr_cnt_reg[ID_BITS-1:0] : id;
        map_wdata = clearing ? '0 : {1'b1, used_reg[SLOT_W-1:0]};
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            used_reg    <= '0;
        end else begin
            if (clearing) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (ctrl.alloc) begin
                used_reg <= used_reg + 1'b1;
            end
        end
    end

    // Memories
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (ctrl.map_rd) begin
            map_rdata_reg <= map_mem[id];
        end
        if (ctrl.ent_wr) begin
            ent_mem[wr_slot] <= {id, wr_calls, wr_cycles};
        end
        if (ctrl.ent_rd) begin
            ent_rdata_reg <= ent_mem[rd_slot];
        end
    end

    assign map_hit   = map_rdata_reg[MW-1];
    assign map_slot  = map_rdata_reg[SLOT_W-1:0];
    assign rd_id     = ent_rdata_reg[EW-1 -: ID_BITS];
    assign rd_calls  = ent_rdata_reg[TS_W+CALLS_W-1 -: CALLS_W];
    assign rd_cycles = ent_rdata_reg[TS_W-1:0];
    assign used      = used_reg;

endmodule

FILE: verif/nested_scope_cycle_profiler_core_test.sv
// Testbench for the nested scope cycle profiler: scoreboard against a behavioral profiler.
`timescale 1ns / 100ps

module nested_scope_cycle_profiler_core_test;
    import nscp_pkg::*;

    localparam int STK_N = DEF_STACK_DEPTH;
    localparam int TBL_N = DEF_TABLE_DEPTH;

    typedef struct packed {
        func_t       func;
        logic [7:0]  scope_id;
        logic [63:0] stamp;
        logic [5:0]  slot;
    } event_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] excl;
        logic [7:0]  ent_id;
        logic [31:0] ent_calls;
        logic [63:0] ent_cycles;
        logic [10:0] depth;
    } report_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [79:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [183:0] m_tdata;
    logic [2:0]   m_tuser;

    nested_scope_cycle_profiler_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Behavioral profiler state
    logic [63:0] fr_start [STK_N];
    logic [63:0] fr_child [STK_N];
    logic [7:0]  fr_id    [STK_N];
    int          depth_now;
    logic [7:0]  tb_id     [TBL_N];
    logic [63:0] tb_cycles [TBL_N];
    logic [31:0] tb_calls  [TBL_N];
    int          tb_used;

    event_t  pending_events[$];
    report_t expected_reports[$];
    int      errors = 0;
    int      n_close = 0, n_open = 0, n_read = 0;
    bit      calm = 1'b0;
    int      hold_rx = 0;

    // Predict the report of one accepted event
    function automatic report_t profile_event(event_t e);
        report_t     r;
        logic [63:0] el;
        int          top;
        r = '0;
        r.status = STAT_OK;
        case (e.func)
            FUNC_OPEN: begin
                n_open++;
                if (depth_now >= STK_N) r.status = STAT_STACK_FULL;
                else begin
                    fr_start[depth_now] = e.stamp;
                    fr_child[depth_now] = '0;
                    fr_id[depth_now] = e.scope_id;
                    depth_now++;
                end
            end
            FUNC_CLOSE: begin
                n_close++;
                if (depth_now == 0) r.status = STAT_STACK_EMPTY;
                else if (fr_id[depth_now-1] != e.scope_id) r.status = STAT_ID_MISMATCH;
                else begin
                    top = depth_now - 1;
                    el = e.stamp - fr_start[top];
                    r.excl = el - fr_child[top];
                    depth_now = top;
                    if (top > 0) fr_child[top-1] += el;
                    r.status = STAT_TABLE_FULL;
                    for (int i = 0; i < tb_used; i++) begin
                        if (tb_id[i] == e.scope_id) begin
                            if (tb_calls[i] != CALLS_MAX) tb_calls[i]++;
                            tb_cycles[i] += r.excl;
                            r.status = STAT_OK;
                            r.ent_id = e.scope_id;
                            r.ent_calls = tb_calls[i];
                            r.ent_cycles = tb_cycles[i];
                            break;
                        end
                    end
                    if (r.status == STAT_TABLE_FULL && tb_used < TBL_N) begin
                        tb_id[tb_used] = e.scope_id;
                        tb_cycles[tb_used] = r.excl;
                        tb_calls[tb_used] = 32'd1;
                        tb_used++;
                        r.status = STAT_OK;
                        r.ent_id = e.scope_id;
                        r.ent_calls = 32'd1;
                        r.ent_cycles = r.excl;
                    end
                end
            end
            FUNC_READ: begin
                n_read++;
                if (e.slot < tb_used) begin
                    r.ent_id = tb_id[e.slot];
                    r.ent_calls = tb_calls[e.slot];
                    r.ent_cycles = tb_cycles[e.slot];
                end else r.status = STAT_SLOT_EMPTY;
            end
            default: ;
        endcase
        r.depth = depth_now[10:0];
        return r;
    endfunction

    function automatic event_t mk_event(func_t f, int id, logic [63:0] ts, int sl);
        event_t e;
        e.func = f;
        e.scope_id = id[7:0];
        e.stamp = ts;
        e.slot = sl[5:0];
        return e;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Driver: offer queued events, with random gaps
    int tx_gap = 0;
    always @(posedge aclk) begin
        event_t e;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                e = pending_events.pop_front();
                expected_reports.push_back(profile_event(e));
            end
            if (s_tvalid && !(s_tready)) begin
                // keep offering the same event
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_events.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_events[0].func;
                s_tdata <= {2'b00, pending_events[0].slot, pending_events[0].stamp,
                            pending_events[0].scope_id};
                if (!calm && $urandom_range(0, 5) == 0) tx_gap <= $urandom_range(1, 6);
            end else s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls plus one long hold-off
    int rx_gap = 0;
    always @(posedge aclk) begin
        report_t got, exp_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                {got.depth, got.ent_cycles, got.ent_calls, got.ent_id, got.excl} = m_tdata[178:0];
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected report %h", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_reports.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch expected st=%0d ex=%h id=%h calls=%h cyc=%h d=%0d",
                                 $time, exp_r.status, exp_r.excl, exp_r.ent_id, exp_r.ent_calls,
                                 exp_r.ent_cycles, exp_r.depth);
                        $display("%0t:          actual   st=%0d ex=%h id=%h calls=%h cyc=%h d=%0d",
                                 $time, got.status, got.excl, got.ent_id, got.ent_calls,
                                 got.ent_cycles, got.depth);
                        errors++;
                    end
                end
            end
            if (hold_rx > 0) begin
                hold_rx <= hold_rx - 1;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) rx_gap <= $urandom_range(1, 6);
            end
        end
    end

    // Push a well-formed nest of random depth with random timing
    task automatic push_nest(int lvl, inout logic [63:0] ts, input int id_range);
        int id, kids;
        id = $urandom_range(0, id_range);
        pending_events.push_back(mk_event(FUNC_OPEN, id, ts, 0));
        ts += $urandom_range(0, 300);
        kids = (lvl < 4) ? $urandom_range(0, 2) : 0;
        for (int k = 0; k < kids; k++) push_nest(lvl + 1, ts, id_range);
        if ($urandom_range(0, 3) == 0)
            pending_events.push_back(mk_event(FUNC_READ, 0, 0, $urandom_range(0, 63)));
        pending_events.push_back(mk_event(FUNC_CLOSE, id, ts, 0));
        ts += $urandom_range(1, 50);
    endtask

    task automatic drain();
        wait (pending_events.size() == 0 && !s_tvalid);
        wait (expected_reports.size() == 0);
        repeat (10) @(posedge aclk);
    endtask

    initial begin
        logic [63:0] ts;
        depth_now = 0;
        tb_used = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty close, slot empty, wrap, mismatch, unknown func, extremes
        pending_events.push_back(mk_event(FUNC_CLOSE, 3, 64'd5, 0));
        pending_events.push_back(mk_event(FUNC_READ, 0, 0, 0));
        pending_events.push_back(mk_event(FUNC_READ, 0, '1, 63));
        pending_events.push_back(mk_event(FUNC_OPEN, 255, '1, 63));
        pending_events.push_back(mk_event(FUNC_OPEN, 0, 64'hFFFF_FFFF_FFFF_FFF0, 0));
        pending_events.push_back(mk_event(FUNC_CLOSE, 255, 64'd3, 0));
        pending_events.push_back(mk_event(FUNC_NONE, 170, 64'hAAAA_5555_AAAA_5555, 42));
        pending_events.push_back(mk_event(FUNC_CLOSE, 0, 64'd20, 0));
        pending_events.push_back(mk_event(FUNC_CLOSE, 255, 64'd30, 0));
        pending_events.push_back(mk_event(FUNC_OPEN, 0, 64'd100, 21));
        pending_events.push_back(mk_event(FUNC_CLOSE, 0, 64'd40, 0));
        pending_events.push_back(mk_event(FUNC_READ, 0, 0, 0));
        pending_events.push_back(mk_event(FUNC_READ, 0, 0, 1));
        pending_events.push_back(mk_event(FUNC_READ, 0, 0, 2));
        pending_events.push_back(mk_event(FUNC_NONE, 85, 64'h5555_AAAA_5555_AAAA, 21));

        // Sender pauses until every expected report has come
        drain();

        // Random nests with few ids, some noise
        ts = rand64();
        while (pending_events.size() < 300) begin
            if ($urandom_range(0, 7) == 0)
                pending_events.push_back(mk_event(func_t'($urandom_range(0, 3)),
                    $urandom_range(0, 255), rand64(), $urandom_range(0, 63)));
            else push_nest(0, ts, 40);
        end

        // Long receiver hold-off while items keep coming
        @(posedge aclk);
        hold_rx = 400;
        drain();

        // Many distinct ids to fill the table, then table-full closes
        while (pending_events.size() < 200) push_nest(2, ts, 255);
        for (int i = 0; i < 64; i++)
            pending_events.push_back(mk_event(FUNC_READ, 0, 0, i));
        calm = 1'b1;
        drain();

        $display("Covered %0d opens, %0d closes, %0d reads; table entries used: %0d.",
                 n_open, n_close, n_read, tb_used);
        $display("Included stack-empty, id mismatch, wrap, unknown func and table fill.");
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: nested_scope_cycle_profiler_core.f
rtl/core/nscp_pkg.sv
rtl/core/nscp_stack.sv
rtl/core/nscp_table.sv
rtl/core/nested_scope_cycle_profiler_core.sv
verif/nested_scope_cycle_profiler_core_test.sv
